// ----- src/drta_pkg.sv -----
// Shared types, codes and constants of the refresh/transaction arbiter.
`timescale 1ns / 1ps

package drta_pkg;

	localparam int RANKS  = 4;
	localparam int RIDX_W = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int TIME_W = 48;
	localparam int ADD_W  = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [1:0] MODE_PEEK     = 2'd0;
	localparam logic [1:0] MODE_PEEK_DLY = 2'd1;
	localparam logic [1:0] MODE_TAKE     = 2'd2;
	localparam logic [1:0] MODE_INIT     = 2'd3;

	localparam logic [1:0] DEC_NONE    = 2'd0;
	localparam logic [1:0] DEC_HEAD    = 2'd1;
	localparam logic [1:0] DEC_REFRESH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_DELAY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STAGGER_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANKS_IN_USE     = 3'd5;

	localparam logic        RST_ENABLE   = 1'b1;
	localparam logic [7:0]  RST_DELAY    = 8'd2;
	localparam logic [15:0] RST_AGE      = 16'd1000;
	localparam logic [19:0] RST_INTERVAL = 20'd7800;
	localparam logic [19:0] RST_STAGGER  = 20'd1951;
	localparam logic [2:0]  RST_RANKS    = 3'd4;

	typedef struct packed {
		logic              enable;
		logic [7:0]        buffer_delay;
		logic [15:0]       age_limit;
		logic [19:0]       interval;
		logic [19:0]       stagger;
		logic [RIDX_W-1:0] rank_last;
	} cfg_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_INIT   = 7'b0000010,
		S_SEARCH = 7'b0000100,
		S_READY  = 7'b0001000,
		S_SENIOR = 7'b0010000,
		S_DUE    = 7'b0100000,
		S_DECIDE = 7'b1000000
	} state_t;

endpackage

// ----- src/dram_refresh_transaction_arbiter.sv -----
// Top level: sequencer, per-rank due-time registers and result register.
`timescale 1ns / 1ps

// A decision item keeps busy high while it searches the tracked ranks (4 by default)
// and runs its later steps, and its result strobe comes in the first idle cycle; a
// new item can be started in the strobe cycle, but not while an item is still busy. An init
// item keeps busy high while it writes the due time of every rank. Every step runs through
// one shared 49-bit adder/comparator: the earliest-due search over the tracked ranks, then
// head readiness, seniority, refresh due and the decision with its due-time advance.
// The result strobe, done, lasts one cycle and cannot be stalled.
module dram_refresh_transaction_arbiter import drta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [TIME_W-1:0]     now,
	input  logic                  head_valid,
	input  logic [TIME_W-1:0]     head_enqueue_time,
	output logic                  done,
	output logic [1:0]            decision,
	output logic [1:0]            refresh_rank,
	output logic [TIME_W-1:0]     refresh_due_time,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg;
	state_t            state_q;
	logic [1:0]        mode_q;
	logic [TIME_W-1:0] now_q;
	logic              hv_q;
	logic [TIME_W-1:0] enq_q;
	logic [RIDX_W-1:0] idx_q;
	logic [RIDX_W-1:0] best_q;
	logic [TIME_W-1:0] best_due_q;
	logic [TIME_W-1:0] acc_q;
	logic              ready_q;
	logic              senior_q;
	logic              due_le_q;
	logic [TIME_W-1:0] due_q [RANKS];
	logic              done_q;
	logic [1:0]        decision_q;
	logic [1:0]        rank_q;
	logic [TIME_W-1:0] due_out_q;

	logic [TIME_W-1:0] alu_a;
	logic [ADD_W-1:0]  alu_add;
	logic [TIME_W-1:0] alu_b;
	logic [TIME_W:0]   alu_sum;
	logic              alu_lt;
	logic              alu_eq;
	logic [TIME_W-1:0] rd_due;
	logic [1:0]        dec_n;

	drta_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	drta_alu u_alu (
		.a   (alu_a),
		.add (alu_add),
		.b   (alu_b),
		.sum (alu_sum),
		.lt  (alu_lt),
		.eq  (alu_eq)
	);

	assign rd_due = due_q[idx_q];

	always_comb begin
		alu_a   = '0;
		alu_add = '0;
		alu_b   = '0;
		unique case (state_q)
			S_INIT: begin
				alu_a   = acc_q;
				alu_add = cfg.stagger;
			end
			S_SEARCH: begin
				alu_a = rd_due;
				alu_b = best_due_q;
			end
			S_READY: begin
				alu_a   = enq_q;
				alu_add = (mode_q == MODE_PEEK) ? '0 : ADD_W'(cfg.buffer_delay);
				alu_b   = now_q;
			end
			S_SENIOR: begin
				alu_a   = best_due_q;
				alu_add = ADD_W'(cfg.age_limit);
				alu_b   = enq_q;
			end
			S_DUE: begin
				alu_a = best_due_q;
				alu_b = now_q;
			end
			S_DECIDE: begin
				alu_a   = best_due_q;
				alu_add = cfg.interval;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (!cfg.enable) begin
			dec_n = (hv_q && ready_q) ? DEC_HEAD : DEC_NONE;
		end else if (hv_q && senior_q && ready_q) begin
			dec_n = DEC_HEAD;
		end else begin
			dec_n = due_le_q ? DEC_REFRESH : DEC_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < RANKS; i++) begin
				due_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= (mode == MODE_INIT) ? S_INIT : S_SEARCH;
					end
				end
				S_INIT: begin
					due_q[idx_q] <= cfg.enable ? acc_q : '0;
					if (idx_q == RIDX_W'(RANKS - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + RIDX_W'(1);
					end
				end
				S_SEARCH: begin
					if (idx_q == cfg.rank_last) begin
						state_q <= S_READY;
					end else begin
						idx_q <= idx_q + RIDX_W'(1);
					end
				end
				S_READY:  state_q <= S_SENIOR;
				S_SENIOR: state_q <= S_DUE;
				S_DUE:    state_q <= S_DECIDE;
				S_DECIDE: begin
					if (mode_q == MODE_TAKE && dec_n == DEC_REFRESH) begin
						due_q[best_q] <= alu_sum[TIME_W-1:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_q     <= mode;
					now_q      <= now;
					hv_q       <= head_valid;
					enq_q      <= head_enqueue_time;
					best_q     <= '0;
					best_due_q <= '1;
					acc_q      <= '0;
				end
			end
			S_INIT: begin
				acc_q <= alu_sum[TIME_W-1:0];
				if (idx_q == RIDX_W'(RANKS - 1)) begin
					decision_q <= DEC_NONE;
					rank_q     <= '0;
					due_out_q  <= '0;
				end
			end
			S_SEARCH: begin
				if (alu_lt) begin
					best_q     <= idx_q;
					best_due_q <= rd_due;
				end
			end
			S_READY:  ready_q  <= alu_lt || alu_eq;
			S_SENIOR: senior_q <= !(alu_lt || alu_eq);
			S_DUE:    due_le_q <= alu_lt || alu_eq;
			S_DECIDE: begin
				decision_q <= dec_n;
				rank_q     <= 2'(best_q);
				due_out_q  <= best_due_q;
			end
			default: ;
		endcase
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign decision         = decision_q;
	assign refresh_rank     = rank_q;
	assign refresh_due_time = due_out_q;

endmodule

// ----- src/drta_cfg.sv -----
// Configuration register file with write decode and tracked-rank clamp.
`timescale 1ns / 1ps

module drta_cfg import drta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic        enable_q;
	logic [7:0]  delay_q;
	logic [15:0] age_q;
	logic [19:0] interval_q;
	logic [19:0] stagger_q;
	logic [2:0]  ranks_q;
	logic [2:0]  ranks_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= RST_ENABLE;
			delay_q    <= RST_DELAY;
			age_q      <= RST_AGE;
			interval_q <= RST_INTERVAL;
			stagger_q  <= RST_STAGGER;
			ranks_q    <= RST_RANKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REFRESH_ENABLE:   enable_q   <= cfg_data[0];
				REG_BUFFER_DELAY:     delay_q    <= cfg_data[7:0];
				REG_AGE_LIMIT:        age_q      <= cfg_data[15:0];
				REG_REFRESH_INTERVAL: interval_q <= cfg_data[19:0];
				REG_STAGGER_STEP:     stagger_q  <= cfg_data[19:0];
				REG_RANKS_IN_USE:     ranks_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ranks_q == 3'd0) begin
			ranks_n = 3'd1;
		end else if (32'(ranks_q) > RANKS) begin
			ranks_n = 3'(RANKS);
		end else begin
			ranks_n = ranks_q;
		end
	end

	assign cfg = '{
		enable:       enable_q,
		buffer_delay: delay_q,
		age_limit:    age_q,
		interval:     interval_q,
		stagger:      stagger_q,
		rank_last:    RIDX_W'(ranks_n - 3'd1)
	};

endmodule

// ----- src/drta_alu.sv -----
// Shared add-and-compare unit: sum = a + add, compared against b.
`timescale 1ns / 1ps

module drta_alu import drta_pkg::*; (
	input  logic [TIME_W-1:0] a,
	input  logic [ADD_W-1:0]  add,
	input  logic [TIME_W-1:0] b,
	output logic [TIME_W:0]   sum,
	output logic              lt,
	output logic              eq
);

	assign sum = (TIME_W+1)'(a) + (TIME_W+1)'(add);
	assign lt  = sum < (TIME_W+1)'(b);
	assign eq  = sum == (TIME_W+1)'(b);

endmodule
